// ===== rtl/core/rscc_pkg.sv =====
// shared types and constants of the record stream continuity checker
package rscc_pkg;

  localparam int unsigned SEQ_W     = 32;
  localparam int unsigned IDX_W     = 64;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned CNT_NUM   = 9;
  localparam int unsigned CNT_IDX_W = 4;

  localparam logic [SEQ_W-1:0] HALF_RANGE = 32'h8000_0000;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_GEN  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_RATE = 8'd1;

  // counter slots: gap counters first, then event counters
  localparam logic [CNT_IDX_W-1:0] CNT_GAP_BASIC   = 4'd0;
  localparam logic [CNT_IDX_W-1:0] CNT_GAP_AGG     = 4'd1;
  localparam logic [CNT_IDX_W-1:0] CNT_GAP_TENMIN  = 4'd2;
  localparam logic [CNT_IDX_W-1:0] CNT_GAP_TWOHOUR = 4'd3;
  localparam logic [CNT_IDX_W-1:0] CNT_INVALID     = 4'd4;
  localparam logic [CNT_IDX_W-1:0] CNT_ACCEPTED    = 4'd5;
  localparam logic [CNT_IDX_W-1:0] CNT_SINGLE      = 4'd6;
  localparam logic [CNT_IDX_W-1:0] CNT_PQ_RECORD   = 4'd7;
  localparam logic [CNT_IDX_W-1:0] CNT_PQ_EVENT    = 4'd8;
  localparam int unsigned          CNT_NUM_GAP     = 4;

  typedef enum logic [1:0] {
    OP_RECORD     = 2'd0,
    OP_CLEAR_BASE = 2'd1,
    OP_NEW_EPOCH  = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    KIND_BASIC      = 3'd0,
    KIND_AGGREGATE  = 3'd1,
    KIND_TEN_MINUTE = 3'd2,
    KIND_TWO_HOUR   = 3'd3,
    KIND_SIBLING    = 3'd4,
    KIND_SINGLE     = 3'd5,
    KIND_PQ_EVENT   = 3'd6,
    KIND_OTHER      = 3'd7
  } kind_e;

  typedef enum logic [2:0] {
    VERDICT_ACCEPTED   = 3'd0,
    VERDICT_BAD_HEADER = 3'd1,
    VERDICT_GEN_MISM   = 3'd2,
    VERDICT_RATE_MISM  = 3'd3,
    VERDICT_STALE      = 3'd4,
    VERDICT_DECODE_REJ = 3'd5,
    VERDICT_CONTROL    = 3'd6
  } verdict_e;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [2:0]       rec_kind;
    logic             hdr_ok;
    logic [31:0]      generation;
    logic [31:0]      sample_rate;
    logic [SEQ_W-1:0] sequence_req;
    logic [SEQ_W-1:0] agg_seq_num;
    logic [IDX_W-1:0] first_idx;
    logic [31:0]      blk_samples;
    logic             decode_ok;
    logic             evt_begin;
  } rec_item_t;

  typedef struct packed {
    verdict_e    verdict;
    logic [30:0] missing_records;
    logic        sample_range_gap;
    logic [31:0] basic_gap_total;
    logic [31:0] aggregate_gap_total;
    logic [31:0] ten_minute_gap_total;
    logic [31:0] two_hour_gap_total;
    logic [31:0] invalid_total;
    logic [31:0] accepted_total;
    logic [31:0] single_cycle_total;
    logic [31:0] pq_record_total;
    logic [31:0] pq_event_total;
  } res_item_t;

  // outcome of one serial-arithmetic compare
  typedef struct packed {
    logic gap;
    logic stale;
  } seq_status_t;

  // per-counter command for one transfer
  typedef struct packed {
    logic        clr;
    logic        add;
    logic [31:0] amount;
  } ctr_ctl_t;

endpackage

// ===== rtl/core/rscc_if.sv =====
// channel interfaces: record input, result output, configuration write
interface rscc_rec_if
  import rscc_pkg::*;
;
  logic      valid;
  logic      ready;
  rec_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rscc_res_if
  import rscc_pkg::*;
;
  logic      valid;
  logic      ready;
  res_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rscc_cfg_if
  import rscc_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [31:0]          wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

// ===== rtl/core/rscc_serial_cmp.sv =====
// half-range serial compare of a received sequence against baseline plus one
module rscc_serial_cmp
  import rscc_pkg::*;
(
  input  logic             has_i,
  input  logic [SEQ_W-1:0] last_i,
  input  logic [SEQ_W-1:0] recv_i,
  output seq_status_t      status_o,
  output logic [SEQ_W-1:0] dist_o
);

  logic [SEQ_W-1:0] diff;

  assign diff = recv_i - last_i - SEQ_W'(1);

  always_comb begin
    status_o = '0;
    dist_o   = '0;
    if (has_i && (diff != '0)) begin
      if (diff < HALF_RANGE) begin
        status_o.gap = 1'b1;
        dist_o       = diff;
      end else begin
        status_o.stale = 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/rscc_sat_ctr.sv =====
// saturating counter with clear, reporting its next value clamped to 32 bits
module rscc_sat_ctr
  import rscc_pkg::*;
#(
  parameter int unsigned COUNTER_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  ctr_ctl_t    ctl_i,
  output logic [31:0] value_o
);

  localparam logic [64:0] CMAX = (65'd1 << COUNTER_WIDTH) - 65'd1;

  logic [COUNTER_WIDTH-1:0] cnt_q, cnt_d;
  logic [64:0]              sum;
  logic [63:0]              ext;

  assign sum = 65'(cnt_q) + 65'(ctl_i.amount);

  always_comb begin
    cnt_d = cnt_q;
    if (en_i) begin
      if (ctl_i.clr) begin
        cnt_d = '0;
      end else if (ctl_i.add) begin
        cnt_d = (sum > CMAX) ? CMAX[COUNTER_WIDTH-1:0] : sum[COUNTER_WIDTH-1:0];
      end
    end
  end

  assign ext     = 64'(cnt_d);
  assign value_o = (ext[63:32] != '0) ? '1 : ext[31:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== rtl/core/record_stream_continuity_checker.sv =====
// record stream continuity checker: top level with stream baselines and counters
//
//   channel  | dir | handshake     | payload
//   ---------+-----+---------------+-----------------------------------------
//   rec_i    | in  | valid / ready | record header or control opcode
//   res_o    | out | valid / ready | verdict, gap report, counter snapshot
//   cfg_i    | in  | valid / ready | register index and write data
//
// one item per cycle while the result is not stalled: a transfer lands in the
// input register, is then evaluated against the baselines and counters, and
// its result is loaded into the result register
// reset clears baselines, counters and configuration; cfg_i is always ready
// a stalled result holds the result register; the input register keeps
// taking a transfer whenever it is empty or moves on in the same cycle
module record_stream_continuity_checker
  import rscc_pkg::*;
#(
  parameter int unsigned COUNTER_WIDTH = 32
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  rscc_rec_if.sink   rec_i,
  rscc_res_if.source res_o,
  rscc_cfg_if.sink   cfg_i
);

  // configuration
  logic [31:0] exp_gen_q, exp_rate_q;

  // input register
  logic      s0_valid_q;
  rec_item_t s0_q;
  logic      s0_fire;

  // result register
  logic      res_valid_q, res_valid_d;
  res_item_t res_q, res_d;

  // stream baselines
  logic             basic_has_q, basic_has_d;
  logic [SEQ_W-1:0] basic_last_q, basic_last_d;
  logic [IDX_W-1:0] next_first_q, next_first_d;
  logic             agg_has_q, agg_has_d;
  logic [SEQ_W-1:0] agg_last_q, agg_last_d;
  logic             tenmin_has_q, tenmin_has_d;
  logic [SEQ_W-1:0] tenmin_last_q, tenmin_last_d;
  logic             twohour_has_q, twohour_has_d;
  logic [SEQ_W-1:0] twohour_last_q, twohour_last_d;

  // tracking selection
  logic                 trk_en;
  logic                 trk_has;
  logic [SEQ_W-1:0]     trk_last;
  logic [SEQ_W-1:0]     trk_recv;
  logic [CNT_IDX_W-1:0] trk_cnt;
  seq_status_t          seq_st;
  logic [SEQ_W-1:0]     seq_dist;
  logic                 basic_trk;

  // counters
  ctr_ctl_t    ctl [CNT_NUM];
  logic [31:0] cnt_val [CNT_NUM];

  verdict_e    verdict;
  logic [30:0] missing;
  logic        srgap;

  // ---------------------------------------------------------------- handshake
  assign s0_fire     = s0_valid_q && (!res_valid_q || res_o.ready);
  assign rec_i.ready = !s0_valid_q || s0_fire;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (rec_i.ready) begin
      s0_valid_q <= rec_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rec_i.valid && rec_i.ready) begin
      s0_q <= rec_i.data;
    end
  end

  // ------------------------------------------------------------ configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_gen_q  <= '0;
      exp_rate_q <= '0;
    end else if (cfg_i.valid && cfg_i.ready) begin
      if (cfg_i.index == CFG_IDX_GEN) begin
        exp_gen_q <= cfg_i.wdata;
      end
      if (cfg_i.index == CFG_IDX_RATE) begin
        exp_rate_q <= cfg_i.wdata;
      end
    end
  end

  // -------------------------------------------------- stream baseline select
  // other basic-tracked records share the basic baseline
  always_comb begin
    trk_en   = 1'b1;
    trk_has  = basic_has_q;
    trk_last = basic_last_q;
    trk_recv = s0_q.sequence_req;
    trk_cnt  = CNT_GAP_BASIC;
    unique case (s0_q.rec_kind)
      KIND_AGGREGATE: begin
        trk_has  = agg_has_q;
        trk_last = agg_last_q;
        trk_recv = s0_q.agg_seq_num;
        trk_cnt  = CNT_GAP_AGG;
      end
      KIND_TEN_MINUTE: begin
        trk_has  = tenmin_has_q;
        trk_last = tenmin_last_q;
        trk_cnt  = CNT_GAP_TENMIN;
      end
      KIND_TWO_HOUR: begin
        trk_has  = twohour_has_q;
        trk_last = twohour_last_q;
        trk_cnt  = CNT_GAP_TWOHOUR;
      end
      KIND_BASIC, KIND_OTHER: begin
        trk_en = 1'b1;
      end
      default: begin
        // siblings, single-cycle and pq records are not tracked
        trk_en = 1'b0;
      end
    endcase
  end

  assign basic_trk = (s0_q.rec_kind == KIND_BASIC) || (s0_q.rec_kind == KIND_OTHER);

  rscc_serial_cmp u_serial_cmp (
    .has_i    (trk_en && trk_has),
    .last_i   (trk_last),
    .recv_i   (trk_recv),
    .status_o (seq_st),
    .dist_o   (seq_dist)
  );

  // -------------------------------------------------------------- evaluation
  always_comb begin
    verdict        = VERDICT_CONTROL;
    missing        = '0;
    srgap          = 1'b0;
    basic_has_d    = basic_has_q;
    basic_last_d   = basic_last_q;
    next_first_d   = next_first_q;
    agg_has_d      = agg_has_q;
    agg_last_d     = agg_last_q;
    tenmin_has_d   = tenmin_has_q;
    tenmin_last_d  = tenmin_last_q;
    twohour_has_d  = twohour_has_q;
    twohour_last_d = twohour_last_q;
    for (int i = 0; i < CNT_NUM; i++) begin
      ctl[i] = '0;
    end

    unique case (s0_q.opcode)
      OP_RECORD: begin
        priority if (!s0_q.hdr_ok) begin
          verdict = VERDICT_BAD_HEADER;
          ctl[CNT_INVALID] = '{clr: 1'b0, add: 1'b1, amount: 32'd1};
        end else if (s0_q.generation != exp_gen_q) begin
          verdict = VERDICT_GEN_MISM;
          ctl[CNT_INVALID] = '{clr: 1'b0, add: 1'b1, amount: 32'd1};
        end else if (s0_q.sample_rate != exp_rate_q) begin
          verdict = VERDICT_RATE_MISM;
          ctl[CNT_INVALID] = '{clr: 1'b0, add: 1'b1, amount: 32'd1};
        end else if (s0_q.rec_kind == KIND_SINGLE) begin
          // decode result does not matter for single-cycle diagnostics
          verdict = VERDICT_ACCEPTED;
          ctl[CNT_SINGLE] = '{clr: 1'b0, add: 1'b1, amount: 32'd1};
        end else if (s0_q.rec_kind == KIND_PQ_EVENT) begin
          if (s0_q.decode_ok) begin
            verdict = VERDICT_ACCEPTED;
            ctl[CNT_PQ_RECORD] = '{clr: 1'b0, add: 1'b1, amount: 32'd1};
            ctl[CNT_PQ_EVENT]  = '{clr: 1'b0, add: s0_q.evt_begin, amount: 32'd1};
          end else begin
            verdict = VERDICT_DECODE_REJ;
            ctl[CNT_INVALID] = '{clr: 1'b0, add: 1'b1, amount: 32'd1};
          end
        end else if (seq_st.stale) begin
          verdict = VERDICT_STALE;
          ctl[CNT_INVALID] = '{clr: 1'b0, add: 1'b1, amount: 32'd1};
        end else begin
          // a gap stays counted even when the decode then fails
          missing = seq_dist[30:0];
          if (seq_st.gap) begin
            ctl[trk_cnt] = '{clr: 1'b0, add: 1'b1, amount: seq_dist};
          end else if (basic_trk && basic_has_q &&
                       (s0_q.first_idx != next_first_q)) begin
            // sample range broke on an exactly consecutive sequence
            srgap = 1'b1;
            ctl[CNT_GAP_BASIC] = '{clr: 1'b0, add: 1'b1, amount: 32'd1};
          end
          if (!s0_q.decode_ok) begin
            verdict = VERDICT_DECODE_REJ;
            ctl[CNT_INVALID] = '{clr: 1'b0, add: 1'b1, amount: 32'd1};
          end else begin
            verdict = VERDICT_ACCEPTED;
            ctl[CNT_ACCEPTED] = '{clr: 1'b0, add: 1'b1, amount: 32'd1};
            unique case (s0_q.rec_kind)
              KIND_BASIC: begin
                basic_has_d  = 1'b1;
                basic_last_d = s0_q.sequence_req;
                next_first_d = s0_q.first_idx + IDX_W'(s0_q.blk_samples);
              end
              KIND_AGGREGATE: begin
                agg_has_d  = 1'b1;
                agg_last_d = s0_q.agg_seq_num;
              end
              KIND_TEN_MINUTE: begin
                tenmin_has_d  = 1'b1;
                tenmin_last_d = s0_q.sequence_req;
              end
              KIND_TWO_HOUR: begin
                twohour_has_d  = 1'b1;
                twohour_last_d = s0_q.sequence_req;
              end
              default: begin
                // siblings and other basic-tracked records leave baselines alone
                basic_has_d = basic_has_q;
              end
            endcase
          end
        end
      end
      OP_CLEAR_BASE, OP_NEW_EPOCH: begin
        basic_has_d    = 1'b0;
        basic_last_d   = '0;
        next_first_d   = '0;
        agg_has_d      = 1'b0;
        agg_last_d     = '0;
        tenmin_has_d   = 1'b0;
        tenmin_last_d  = '0;
        twohour_has_d  = 1'b0;
        twohour_last_d = '0;
        if (s0_q.opcode == OP_NEW_EPOCH) begin
          for (int i = 0; i < CNT_NUM_GAP; i++) begin
            ctl[i] = '{clr: 1'b1, add: 1'b0, amount: 32'd0};
          end
        end
      end
      default: begin
        // unused opcode only answers control done
        verdict = VERDICT_CONTROL;
      end
    endcase
  end

  // ---------------------------------------------------------------- counters
  for (genvar g = 0; g < CNT_NUM; g++) begin : g_ctr
    rscc_sat_ctr #(
      .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_ctr (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (s0_fire),
      .ctl_i   (ctl[g]),
      .value_o (cnt_val[g])
    );
  end

  // ---------------------------------------------------------- baseline state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      basic_has_q    <= 1'b0;
      basic_last_q   <= '0;
      next_first_q   <= '0;
      agg_has_q      <= 1'b0;
      agg_last_q     <= '0;
      tenmin_has_q   <= 1'b0;
      tenmin_last_q  <= '0;
      twohour_has_q  <= 1'b0;
      twohour_last_q <= '0;
    end else if (s0_fire) begin
      basic_has_q    <= basic_has_d;
      basic_last_q   <= basic_last_d;
      next_first_q   <= next_first_d;
      agg_has_q      <= agg_has_d;
      agg_last_q     <= agg_last_d;
      tenmin_has_q   <= tenmin_has_d;
      tenmin_last_q  <= tenmin_last_d;
      twohour_has_q  <= twohour_has_d;
      twohour_last_q <= twohour_last_d;
    end
  end

  // ---------------------------------------------------------- result register
  always_comb begin
    res_d.verdict              = verdict;
    res_d.missing_records      = missing;
    res_d.sample_range_gap     = srgap;
    res_d.basic_gap_total      = cnt_val[CNT_GAP_BASIC];
    res_d.aggregate_gap_total  = cnt_val[CNT_GAP_AGG];
    res_d.ten_minute_gap_total = cnt_val[CNT_GAP_TENMIN];
    res_d.two_hour_gap_total   = cnt_val[CNT_GAP_TWOHOUR];
    res_d.invalid_total        = cnt_val[CNT_INVALID];
    res_d.accepted_total       = cnt_val[CNT_ACCEPTED];
    res_d.single_cycle_total   = cnt_val[CNT_SINGLE];
    res_d.pq_record_total      = cnt_val[CNT_PQ_RECORD];
    res_d.pq_event_total       = cnt_val[CNT_PQ_EVENT];
  end

  always_comb begin
    res_valid_d = res_valid_q;
    if (s0_fire) begin
      res_valid_d = 1'b1;
    end else if (res_o.ready) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s0_fire) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid = res_valid_q;
  assign res_o.data  = res_q;

`ifndef SYNTHESIS
  // a result only appears after an item left the input register
  a_res_from_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_q) |-> $past(s0_fire))
    else $error("result valid without an evaluated item");

  // control items never report gaps
  a_ctrl_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && (res_q.verdict == VERDICT_CONTROL)) |->
      ((res_q.missing_records == '0) && !res_q.sample_range_gap))
    else $error("control item reported a gap");

  // a sample range break only comes with a tracked, non-stale record
  a_srgap_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_q.sample_range_gap) |->
      ((res_q.verdict == VERDICT_ACCEPTED) || (res_q.verdict == VERDICT_DECODE_REJ)))
    else $error("sample range gap with unexpected verdict");

  // an empty input register always takes a transfer
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s0_valid_q |-> rec_i.ready)
    else $error("input stalled while input register empty");
`endif

endmodule

// ===== verif/tb_top.sv =====
// self-checking testbench for the record stream continuity checker
module tb_top;
  import rscc_pkg::*;

  localparam int unsigned COUNTER_WIDTH = 32;
  localparam logic [63:0] CTR_MAX = (COUNTER_WIDTH >= 64) ? '1 :
                                    ((64'd1 << COUNTER_WIDTH) - 64'd1);
  localparam logic [1:0]  OP_UNUSED   = 2'd3;  // opcode outside the defined set
  localparam int unsigned DRAIN_PAUSE = 8;     // margin after the last result before the next phase
  localparam int unsigned HOLD_CYCLES = 120;   // long result stall to back up the input
  localparam int unsigned MAX_PRINTS  = 40;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // testbench-side drivers, known from time zero
  logic                 rec_valid = 1'b0;
  rec_item_t            rec_data  = '0;
  logic                 res_ready = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_wdata = '0;

  rscc_rec_if rec_if ();
  rscc_res_if res_if ();
  rscc_cfg_if cfg_if ();

  assign rec_if.valid = rec_valid;
  assign rec_if.data  = rec_data;
  assign res_if.ready = res_ready;
  assign cfg_if.valid = cfg_valid;
  assign cfg_if.index = cfg_index;
  assign cfg_if.wdata = cfg_wdata;

  record_stream_continuity_checker #(
    .COUNTER_WIDTH(COUNTER_WIDTH)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .rec_i (rec_if.sink),
    .res_o (res_if.source),
    .cfg_i (cfg_if.sink)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // predictor state: one baseline per stream slot, same order as gap counters
  // ---------------------------------------------------------------------------
  logic [31:0] want_gen  = '0;
  logic [31:0] want_rate = '0;
  logic        base_seen [CNT_NUM_GAP] = '{default: 1'b0};
  logic [31:0] base_seq  [CNT_NUM_GAP] = '{default: '0};
  logic [63:0] next_first = '0;
  logic [63:0] ctr [CNT_NUM] = '{default: '0};

  rec_item_t pending_items [$];
  res_item_t expected_results [$];
  int unsigned error_count = 0;

  // stimulus side
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned phase_no = 0;
  logic        rx_hold = 1'b0;
  logic [31:0] stim_gen = '0;
  logic [31:0] stim_rate = '0;
  logic [31:0] stim_seq [CNT_NUM_GAP] = '{default: '0};
  logic [63:0] stim_first = '0;

  function automatic logic [63:0] sat_add(input logic [63:0] c, input logic [63:0] d);
    if (c > CTR_MAX) c = CTR_MAX;
    return (d > CTR_MAX - c) ? CTR_MAX : c + d;
  endfunction

  function automatic logic [31:0] clamp32(input logic [63:0] v);
    return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  // half-range serial compare of a received sequence against baseline + 1
  function automatic seq_status_t seq_compare(input logic has, input logic [31:0] last,
                                              input logic [31:0] recv,
                                              output logic [31:0] gap_len);
    logic [31:0] d;
    seq_status_t s;
    s       = '0;
    gap_len = '0;
    if (!has) return s;
    d = recv - (last + 32'd1);
    if (d == 32'd0) return s;
    if (d < HALF_RANGE) begin
      gap_len = d;
      s.gap   = 1'b1;
    end else begin
      s.stale = 1'b1;
    end
    return s;
  endfunction

  function automatic void clear_baselines();
    int i;
    for (i = 0; i < CNT_NUM_GAP; i++) begin
      base_seen[i] = 1'b0;
      base_seq[i]  = '0;
    end
    next_first = '0;
  endfunction

  function automatic verdict_e apply_record(input rec_item_t it, output logic [30:0] missing,
                                            output logic srgap);
    kind_e       kind;
    logic [3:0]  slot;
    logic        tracked;
    logic [31:0] seq;
    logic [31:0] gap_len;
    seq_status_t st;
    missing = '0;
    srgap   = 1'b0;
    gap_len = '0;
    st      = '0;
    seq     = '0;
    slot    = CNT_GAP_BASIC;
    tracked = 1'b1;
    kind    = kind_e'(it.rec_kind);

    // envelope checks come before anything stream specific
    if (!it.hdr_ok) begin
      ctr[CNT_INVALID] = sat_add(ctr[CNT_INVALID], 64'd1);
      return VERDICT_BAD_HEADER;
    end
    if (it.generation != want_gen) begin
      ctr[CNT_INVALID] = sat_add(ctr[CNT_INVALID], 64'd1);
      return VERDICT_GEN_MISM;
    end
    if (it.sample_rate != want_rate) begin
      ctr[CNT_INVALID] = sat_add(ctr[CNT_INVALID], 64'd1);
      return VERDICT_RATE_MISM;
    end

    // single-cycle ignores the decoder; pq records count apart from accepted
    if (kind == KIND_SINGLE) begin
      ctr[CNT_SINGLE] = sat_add(ctr[CNT_SINGLE], 64'd1);
      return VERDICT_ACCEPTED;
    end
    if (kind == KIND_PQ_EVENT) begin
      if (!it.decode_ok) begin
        ctr[CNT_INVALID] = sat_add(ctr[CNT_INVALID], 64'd1);
        return VERDICT_DECODE_REJ;
      end
      ctr[CNT_PQ_RECORD] = sat_add(ctr[CNT_PQ_RECORD], 64'd1);
      if (it.evt_begin) ctr[CNT_PQ_EVENT] = sat_add(ctr[CNT_PQ_EVENT], 64'd1);
      return VERDICT_ACCEPTED;
    end

    case (kind)
      KIND_BASIC, KIND_OTHER: slot = CNT_GAP_BASIC;
      KIND_AGGREGATE:         slot = CNT_GAP_AGG;
      KIND_TEN_MINUTE:        slot = CNT_GAP_TENMIN;
      KIND_TWO_HOUR:          slot = CNT_GAP_TWOHOUR;
      default:                tracked = 1'b0;  // siblings carry no continuity
    endcase

    if (tracked) begin
      seq = (slot == CNT_GAP_AGG) ? it.agg_seq_num : it.sequence_req;
      st  = seq_compare(base_seen[slot], base_seq[slot], seq, gap_len);
      if (st.gap) ctr[slot] = sat_add(ctr[slot], 64'(gap_len));
      // sample continuity only matters when the sequence is exactly next
      if (slot == CNT_GAP_BASIC && !st.gap && !st.stale && base_seen[slot] &&
          it.first_idx != next_first) begin
        ctr[slot] = sat_add(ctr[slot], 64'd1);
        srgap     = 1'b1;
      end
    end

    if (st.stale) begin
      ctr[CNT_INVALID] = sat_add(ctr[CNT_INVALID], 64'd1);
      return VERDICT_STALE;
    end
    // a gap stays reported even when the decode fails below
    missing = gap_len[30:0];
    if (!it.decode_ok) begin
      ctr[CNT_INVALID] = sat_add(ctr[CNT_INVALID], 64'd1);
      return VERDICT_DECODE_REJ;
    end
    ctr[CNT_ACCEPTED] = sat_add(ctr[CNT_ACCEPTED], 64'd1);
    // other basic-tracked records check against the basic baseline but never move it
    if (tracked && kind != KIND_OTHER) begin
      base_seen[slot] = 1'b1;
      base_seq[slot]  = seq;
      if (kind == KIND_BASIC) next_first = it.first_idx + 64'(it.blk_samples);
    end
    return VERDICT_ACCEPTED;
  endfunction

  function automatic res_item_t predict_outcome(input rec_item_t it);
    res_item_t   r;
    logic [30:0] missing;
    logic        srgap;
    int          i;
    r       = '0;
    missing = '0;
    srgap   = 1'b0;
    if (it.opcode == OP_RECORD) begin
      r.verdict = apply_record(it, missing, srgap);
    end else begin
      if (it.opcode == OP_CLEAR_BASE || it.opcode == OP_NEW_EPOCH) clear_baselines();
      if (it.opcode == OP_NEW_EPOCH)
        for (i = 0; i < CNT_NUM_GAP; i++) ctr[i] = '0;
      r.verdict = VERDICT_CONTROL;
    end
    r.missing_records  = missing;
    r.sample_range_gap = srgap;
    for (i = 0; i < CNT_NUM; i++) r[32*(CNT_NUM-1-i) +: 32] = clamp32(ctr[i]);
    return r;
  endfunction

  task automatic flag_mismatch(input string msg);
    error_count++;
    if (error_count <= MAX_PRINTS) $display("mismatch at %0t: %s", $time, msg);
  endtask

  task automatic compare_result(input res_item_t got, input res_item_t want);
    int i;
    if (got.verdict !== want.verdict)
      flag_mismatch($sformatf("verdict got %0d want %0d", got.verdict, want.verdict));
    if (got.missing_records !== want.missing_records)
      flag_mismatch($sformatf("missing_records got %0d want %0d",
                              got.missing_records, want.missing_records));
    if (got.sample_range_gap !== want.sample_range_gap)
      flag_mismatch($sformatf("sample_range_gap got %0b want %0b",
                              got.sample_range_gap, want.sample_range_gap));
    // the nine counter snapshots sit in slot order below the report fields
    for (i = 0; i < CNT_NUM; i++)
      if (got[32*(CNT_NUM-1-i) +: 32] !== want[32*(CNT_NUM-1-i) +: 32])
        flag_mismatch($sformatf("counter slot %0d got %h want %h", i,
                                got[32*(CNT_NUM-1-i) +: 32], want[32*(CNT_NUM-1-i) +: 32]));
  endtask

  // ---------------------------------------------------------------------------
  // record driver: predicts each transfer, then offers the next pending item
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rec_valid <= 1'b0;
    end else begin
      if (rec_valid && rec_if.ready) expected_results.push_back(predict_outcome(rec_data));
      if (!rec_valid || rec_if.ready) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          rec_valid <= 1'b1;
          rec_data  <= pending_items.pop_front();
        end else begin
          rec_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor: checks each transfer against the oldest prediction
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      res_ready <= 1'b0;
    end else begin
      if (res_if.valid && res_ready) begin
        if (expected_results.size() == 0) flag_mismatch("result with no record pending");
        else compare_result(res_if.data, expected_results.pop_front());
      end
      res_ready <= !rx_hold && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // register shadow for the predictor, follows the write channel
  always @(posedge clk_i) begin
    if (rst_ni && cfg_valid && cfg_if.ready) begin
      case (cfg_index)
        CFG_IDX_GEN:  want_gen  <= cfg_wdata;
        CFG_IDX_RATE: want_rate <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // long result stall in the last phase so the input side backs up
  initial begin
    while (phase_no != 4 || pending_items.size() > 170) @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] pick_sequence(input logic [31:0] last);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 78) return last + 32'd1;
    if (roll < 86) return last + 32'($urandom_range(2, 6));
    if (roll < 90) return last + 32'd1 + ($urandom & 32'h7FFF_FFFF);
    if (roll < 95) return last - 32'($urandom_range(0, 3));
    return $urandom;
  endfunction

  function automatic rec_item_t make_item();
    rec_item_t   it;
    int unsigned roll;
    it.opcode       = OP_RECORD;
    it.rec_kind     = 3'($urandom);
    it.hdr_ok       = 1'($urandom);
    it.generation   = $urandom;
    it.sample_rate  = $urandom;
    it.sequence_req = $urandom;
    it.agg_seq_num  = $urandom;
    it.first_idx    = {$urandom, $urandom};
    it.blk_samples  = $urandom;
    it.decode_ok    = 1'($urandom);
    it.evt_begin    = 1'($urandom);

    roll = $urandom_range(99);
    if (roll < 2) begin
      it.opcode = OP_CLEAR_BASE;
      return it;
    end
    if (roll == 2) begin
      it.opcode = OP_NEW_EPOCH;
      return it;
    end
    if (roll == 3) begin
      it.opcode = OP_UNUSED;
      return it;
    end

    // well-formed record with random content, a few noisy envelopes
    roll = $urandom_range(19);
    if (roll < 7)       it.rec_kind = KIND_BASIC;
    else if (roll < 10) it.rec_kind = KIND_AGGREGATE;
    else if (roll < 12) it.rec_kind = KIND_TEN_MINUTE;
    else if (roll < 14) it.rec_kind = KIND_TWO_HOUR;
    else if (roll < 15) it.rec_kind = KIND_SIBLING;
    else if (roll < 16) it.rec_kind = KIND_SINGLE;
    else if (roll < 18) it.rec_kind = KIND_PQ_EVENT;
    else                it.rec_kind = KIND_OTHER;
    it.hdr_ok = ($urandom_range(99) >= 3);
    if ($urandom_range(99) < 96) it.generation  = stim_gen;
    if ($urandom_range(99) < 96) it.sample_rate = stim_rate;
    it.decode_ok = ($urandom_range(99) >= 8);

    case (it.rec_kind)
      KIND_AGGREGATE: begin
        it.agg_seq_num = pick_sequence(stim_seq[CNT_GAP_AGG]);
        if (it.decode_ok) stim_seq[CNT_GAP_AGG] = it.agg_seq_num;
      end
      KIND_TEN_MINUTE: begin
        it.sequence_req = pick_sequence(stim_seq[CNT_GAP_TENMIN]);
        if (it.decode_ok) stim_seq[CNT_GAP_TENMIN] = it.sequence_req;
      end
      KIND_TWO_HOUR: begin
        it.sequence_req = pick_sequence(stim_seq[CNT_GAP_TWOHOUR]);
        if (it.decode_ok) stim_seq[CNT_GAP_TWOHOUR] = it.sequence_req;
      end
      KIND_BASIC, KIND_OTHER: begin
        it.sequence_req = pick_sequence(stim_seq[CNT_GAP_BASIC]);
        if ($urandom_range(99) < 90) it.first_idx = stim_first;
        if ($urandom_range(99) < 90) it.blk_samples = 32'($urandom_range(1, 256));
        if (it.rec_kind == KIND_BASIC && it.decode_ok) begin
          stim_seq[CNT_GAP_BASIC] = it.sequence_req;
          stim_first = it.first_idx + 64'(it.blk_samples);
        end
      end
      default: ;
    endcase
    return it;
  endfunction

  function automatic rec_item_t dir_rec(input kind_e kind, input logic [31:0] seq,
                                        input logic [31:0] aseq, input logic [63:0] first,
                                        input logic [31:0] count, input logic ok,
                                        input logic evs);
    rec_item_t it;
    it.opcode       = OP_RECORD;
    it.rec_kind     = kind;
    it.hdr_ok       = 1'b1;
    it.generation   = stim_gen;
    it.sample_rate  = stim_rate;
    it.sequence_req = seq;
    it.agg_seq_num  = aseq;
    it.first_idx    = first;
    it.blk_samples  = count;
    it.decode_ok    = ok;
    it.evt_begin    = evs;
    return it;
  endfunction

  task automatic push_directed();
    rec_item_t it;
    // unused opcode, then each envelope rejection
    it = dir_rec(KIND_BASIC, 32'd0, 32'd0, 64'd0, 32'd0, 1'b1, 1'b0);
    it.opcode = OP_UNUSED;
    pending_items.push_back(it);
    it = dir_rec(KIND_BASIC, 32'd0, 32'd0, 64'd0, 32'd0, 1'b1, 1'b0);
    it.hdr_ok = 1'b0;
    pending_items.push_back(it);
    it = dir_rec(KIND_BASIC, 32'd0, 32'd0, 64'd0, 32'd0, 1'b1, 1'b0);
    it.generation = ~stim_gen;
    pending_items.push_back(it);
    it = dir_rec(KIND_BASIC, 32'd0, 32'd0, 64'd0, 32'd0, 1'b1, 1'b0);
    it.sample_rate = ~stim_rate;
    pending_items.push_back(it);
    // basic baseline at the top of both ranges, then wrap of sample index and sequence
    pending_items.push_back(dir_rec(KIND_BASIC, 32'hFFFF_FFFE, 32'd0,
                                    64'hFFFF_FFFF_FFFF_FFF0, 32'h20, 1'b1, 1'b0));
    pending_items.push_back(dir_rec(KIND_BASIC, 32'hFFFF_FFFF, 32'd0,
                                    64'h10, 32'hFFFF_FFFF, 1'b1, 1'b0));
    // consecutive sequence with a broken sample range
    pending_items.push_back(dir_rec(KIND_BASIC, 32'd0, 32'd0, 64'h5, 32'h8, 1'b1, 1'b0));
    // other basic-tracked twice: baseline must not move
    pending_items.push_back(dir_rec(KIND_OTHER, 32'd1, 32'd0, 64'hD, 32'd4, 1'b1, 1'b0));
    pending_items.push_back(dir_rec(KIND_OTHER, 32'd1, 32'd0, 64'hD, 32'd4, 1'b1, 1'b0));
    // largest forward gap on a record whose decode fails
    pending_items.push_back(dir_rec(KIND_BASIC, 32'h8000_0000, 32'd0, 64'd0, 32'd1,
                                    1'b0, 1'b0));
    // half range ahead and a repeat are both stale
    pending_items.push_back(dir_rec(KIND_BASIC, 32'h8000_0001, 32'd0, 64'd0, 32'd1,
                                    1'b1, 1'b0));
    pending_items.push_back(dir_rec(KIND_BASIC, 32'd0, 32'd0, 64'hD, 32'd1, 1'b1, 1'b0));
    // aggregate uses its own sequence field
    pending_items.push_back(dir_rec(KIND_AGGREGATE, 32'hFFFF, 32'd5, 64'd0, 32'd0,
                                    1'b1, 1'b0));
    pending_items.push_back(dir_rec(KIND_AGGREGATE, 32'd0, 32'd9, 64'd0, 32'd0, 1'b1, 1'b0));
    pending_items.push_back(dir_rec(KIND_TEN_MINUTE, 32'd100, 32'd0, 64'd0, 32'd0,
                                    1'b1, 1'b0));
    pending_items.push_back(dir_rec(KIND_TEN_MINUTE, 32'd103, 32'd0, 64'd0, 32'd0,
                                    1'b1, 1'b0));
    // three maximal two-hour gaps drive the counter into saturation
    pending_items.push_back(dir_rec(KIND_TWO_HOUR, 32'd0, 32'd0, 64'd0, 32'd0, 1'b1, 1'b0));
    pending_items.push_back(dir_rec(KIND_TWO_HOUR, 32'h8000_0000, 32'd0, 64'd0, 32'd0,
                                    1'b1, 1'b0));
    pending_items.push_back(dir_rec(KIND_TWO_HOUR, 32'd0, 32'd0, 64'd0, 32'd0, 1'b1, 1'b0));
    pending_items.push_back(dir_rec(KIND_TWO_HOUR, 32'h8000_0000, 32'd0, 64'd0, 32'd0,
                                    1'b1, 1'b0));
    // untracked kinds
    pending_items.push_back(dir_rec(KIND_SIBLING, 32'd7, 32'd7, 64'd0, 32'd0, 1'b1, 1'b0));
    pending_items.push_back(dir_rec(KIND_SINGLE, 32'd0, 32'd0, 64'd0, 32'd0, 1'b0, 1'b0));
    pending_items.push_back(dir_rec(KIND_PQ_EVENT, 32'd0, 32'd0, 64'd0, 32'd0, 1'b1, 1'b1));
    pending_items.push_back(dir_rec(KIND_PQ_EVENT, 32'd0, 32'd0, 64'd0, 32'd0, 1'b0, 1'b1));
    // clear baselines: the next basic record starts fresh, then a new epoch
    it = dir_rec(KIND_BASIC, 32'd0, 32'd0, 64'd0, 32'd0, 1'b1, 1'b0);
    it.opcode = OP_CLEAR_BASE;
    pending_items.push_back(it);
    pending_items.push_back(dir_rec(KIND_BASIC, 32'h1234_5678, 32'd0, 64'h99, 32'd3,
                                    1'b1, 1'b0));
    it.opcode = OP_NEW_EPOCH;
    pending_items.push_back(it);
  endtask

  task automatic write_regs(input logic [31:0] gen, input logic [31:0] rate);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_IDX_GEN;
    cfg_wdata <= gen;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_index <= CFG_IDX_RATE;
    cfg_wdata <= rate;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_valid <= 1'b0;
  endtask

  // one configuration setting, one idling mode, then drain to idle
  task automatic run_phase(input int unsigned p, input logic [31:0] gen,
                           input logic [31:0] rate, input int unsigned s_pct,
                           input int unsigned r_pct, input int unsigned n_items);
    write_regs(gen, rate);
    stim_gen      = gen;
    stim_rate     = rate;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    phase_no      = p;
    if (p == 0) push_directed();
    repeat (n_items) pending_items.push_back(make_item());
    while (pending_items.size() != 0 || rec_valid || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_PAUSE) @(posedge clk_i);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    run_phase(0, 32'h0000_0000, 32'h0000_0000, 14, 54, 190);
    run_phase(1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 14, 54, 220);
    run_phase(2, $urandom, $urandom, 54, 14, 220);
    run_phase(3, 32'h0000_0000, 32'hFFFF_FFFF, 54, 14, 220);
    run_phase(4, $urandom, $urandom, 0, 0, 220);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // run limit, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
